// ===== src/sob_pkg.sv =====
// ----------------------------------------------------------------------------
// sob_pkg
// Shared types and constants of the Sobel edge magnitude block.
// ----------------------------------------------------------------------------
package sob_pkg;

    localparam int CHANNEL_BITS  = 8;
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int FW_BITS       = 11;
    localparam int FH_BITS       = 12;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 12;

    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_HEIGHT = 2'd1;

    localparam logic [FW_BITS-1:0] FRAME_WIDTH_RST  = 11'd640;
    localparam logic [FH_BITS-1:0] FRAME_HEIGHT_RST = 12'd480;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef struct packed {
        logic       operation;
        logic [7:0] in_blue;
        logic [7:0] in_green;
        logic [7:0] in_red;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_blue;
        logic [7:0] out_green;
        logic [7:0] out_red;
        logic       frame_last;
    } t_out_item;

    // Channel 0 is blue, 1 green, 2 red.
    typedef logic [2:0][CHANNEL_BITS-1:0] t_pix;

    // Columns left, center, right; rows top, middle, bottom; one channel.
    typedef logic [2:0][2:0][CHANNEL_BITS-1:0] t_lane_win;

endpackage

// ===== src/sob_ram.sv =====
// ----------------------------------------------------------------------------
// sob_ram
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module sob_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/sob_lane.sv =====
// ----------------------------------------------------------------------------
// sob_lane
// One channel lane: Sobel gradients, sum of squares and a digit-by-digit
// square root that yields the rounded, capped magnitude.
// ----------------------------------------------------------------------------
module sob_lane
    import sob_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  t_lane_win               i_win,
    output logic                    o_done,
    output logic [CHANNEL_BITS-1:0] o_mag
);

    localparam int GW  = CHANNEL_BITS + 2;
    localparam int SW  = 2 * GW + 1;
    localparam int N   = GW + 2;
    localparam int NCW = $clog2(N + 1);

    localparam logic [1:0] P_IDLE = 2'd0;
    localparam logic [1:0] P_SQR  = 2'd1;
    localparam logic [1:0] P_ROOT = 2'd2;

    logic [1:0]       r_phase, n_phase;
    logic [NCW-1:0]   r_cnt, n_cnt;
    logic             r_done, n_done;
    logic [GW-1:0]    r_ax, r_ay;
    logic [2*N-1:0]   r_val, n_val;
    logic [N-1:0]     r_root, n_root;
    logic [N+1:0]     r_rem, n_rem;

    logic signed [GW:0] gx, gy, pos_x, neg_x, pos_y, neg_y;
    logic [SW-1:0]      sum_sq;
    logic [N+3:0]       rem_sh, trial;
    logic [N:0]         rounded;

    always_comb begin
        pos_x = (GW+1)'(i_win[2][0]) + ((GW+1)'(i_win[2][1]) <<< 1) + (GW+1)'(i_win[2][2]);
        neg_x = (GW+1)'(i_win[0][0]) + ((GW+1)'(i_win[0][1]) <<< 1) + (GW+1)'(i_win[0][2]);
        pos_y = (GW+1)'(i_win[0][2]) + ((GW+1)'(i_win[1][2]) <<< 1) + (GW+1)'(i_win[2][2]);
        neg_y = (GW+1)'(i_win[0][0]) + ((GW+1)'(i_win[1][0]) <<< 1) + (GW+1)'(i_win[2][0]);
        gx    = pos_x - neg_x;
        gy    = pos_y - neg_y;
        sum_sq = SW'(r_ax * r_ax) + SW'(r_ay * r_ay);
        rem_sh = {r_rem, r_val[2*N-1 -: 2]};
        trial  = {2'b00, r_root, 2'b01};
        rounded = ((N+1)'(r_root) + (N+1)'(1)) >> 1;
    end

    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        n_val   = r_val;
        n_root  = r_root;
        n_rem   = r_rem;
        case (r_phase)
            P_IDLE: begin
                if (i_start) begin
                    n_phase = P_SQR;
                end
            end
            P_SQR: begin
                n_val   = (2*N)'({sum_sq, 2'b00});
                n_root  = '0;
                n_rem   = '0;
                n_cnt   = '0;
                n_phase = P_ROOT;
            end
            P_ROOT: begin
                n_val = r_val << 2;
                if (rem_sh >= trial) begin
                    n_rem  = (N+2)'(rem_sh - trial);
                    n_root = {r_root[N-2:0], 1'b1};
                end else begin
                    n_rem  = (N+2)'(rem_sh);
                    n_root = {r_root[N-2:0], 1'b0};
                end
                n_cnt = r_cnt + NCW'(1);
                if (r_cnt == NCW'(N - 1)) begin
                    n_phase = P_IDLE;
                    n_done  = 1'b1;
                end
            end
            default: begin
                n_phase = P_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_done  <= n_done;
        end
        if (r_phase == P_IDLE && i_start) begin
            r_ax <= gx[GW] ? GW'(-gx) : GW'(gx);
            r_ay <= gy[GW] ? GW'(-gy) : GW'(gy);
        end
        r_cnt  <= n_cnt;
        r_val  <= n_val;
        r_root <= n_root;
        r_rem  <= n_rem;
    end

    assign o_done = r_done;
    assign o_mag  = (rounded > (N+1)'({CHANNEL_BITS{1'b1}})) ? {CHANNEL_BITS{1'b1}}
                                                            : CHANNEL_BITS'(rounded);

endmodule

// ===== src/sobel_edge_magnitude_rgb_top.sv =====
// A result passes the read, column and lane states, then waits to load the output stage.
// A new item is taken only in idle, so the square root iteration sets the pace.
// An item with no result ends in the column state; an ignored flush ends in idle.
// Synchronous active-low reset clears the window, the counters and the output stage.
// The line stores are not cleared; entries are used only after being written in the frame.
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_rgb_top
// RGB Sobel edge magnitude over a raster stream with two line stores,
// three channel lanes and a merging output stage.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_rgb_top
    import sob_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  t_in_item                 i_in_data,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output t_out_item                o_out_data,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int EW    = FH_BITS + WW;
    localparam int ROW_W = FH_BITS + 1;
    localparam int PW    = 3 * CHANNEL_BITS;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_COL  = 3'd2;
    localparam logic [2:0] S_LANE = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]         r_state;
    logic [FW_BITS-1:0] r_fw;
    logic [FH_BITS-1:0] r_fh;
    logic [EW-1:0]      r_total;
    logic [CW-1:0]      r_col;
    logic [ROW_W-1:0]   r_row;
    logic [EW-1:0]      r_emitted;
    logic [2:0]         r_win_valid_unused;
    t_pix [2:0][2:0]    r_win;
    t_pix               r_pix;
    logic               r_drain;
    logic               r_last;
    logic               r_out_valid;
    t_out_item          r_out;

    logic [WW-1:0]      w_eff;
    logic [FH_BITS-1:0] h_eff;
    logic               draining;
    logic [CW-1:0]      c_use;
    logic [WW-1:0]      c_inc;
    t_pix               up_rd, mid_rd;
    t_pix [2:0]         col;
    t_pix [2:0]         win_l, win_c, win_r;
    logic               emit;
    logic               last_out;
    logic               lane_start;
    logic [2:0]         lane_done;
    logic [2:0][CHANNEL_BITS-1:0] lane_mag;
    t_lane_win [2:0]    lane_win;
    logic               store_we;
    logic               out_load;

    always_comb begin
        if (r_fw == '0) begin
            w_eff = WW'(1);
        end else if (int'(r_fw) > MAX_WIDTH) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_fw);
        end
        h_eff    = (r_fh == '0) ? FH_BITS'(1) : r_fh;
        draining = r_row >= ROW_W'(h_eff);
        c_use    = (WW'(r_col) >= w_eff) ? '0 : r_col;
        c_inc    = WW'(c_use) + WW'(1);
    end

    sob_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_upper (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (c_use),
        .i_wdata (mid_rd),
        .i_raddr (c_use),
        .o_rdata (up_rd)
    );

    sob_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_middle (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (c_use),
        .i_wdata (r_pix),
        .i_raddr (c_use),
        .o_rdata (mid_rd)
    );

    always_comb begin
        col[0] = (r_row >= ROW_W'(2)) ? up_rd : '0;
        col[1] = (r_row >= ROW_W'(1) && r_row <= ROW_W'(h_eff)) ? mid_rd : '0;
        col[2] = r_pix;
        emit   = (r_row >= ROW_W'(2)) || (r_row == ROW_W'(1) && c_use != '0);
        last_out = ((EW+1)'(r_emitted) + (EW+1)'(1)) >= (EW+1)'(r_total);
        if (c_use == '0) begin
            win_l = (w_eff >= WW'(2)) ? r_win[1] : '0;
            win_c = r_win[2];
            win_r = '0;
        end else begin
            win_l = (c_use == CW'(1)) ? '0 : r_win[1];
            win_c = r_win[2];
            win_r = col;
        end
        for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
                lane_win[k][0][j] = win_l[j][k];
                lane_win[k][1][j] = win_c[j][k];
                lane_win[k][2][j] = win_r[j][k];
            end
        end
        lane_start = (r_state == S_COL) && emit;
        store_we   = (r_state == S_COL) && !r_drain;
        out_load   = (r_state == S_OUT) && (!r_out_valid || i_out_ready);
    end

    for (genvar g = 0; g < 3; g++) begin : g_lane
        sob_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (lane_start),
            .i_win   (lane_win[g]),
            .o_done  (lane_done[g]),
            .o_mag   (lane_mag[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fw        <= FRAME_WIDTH_RST;
            r_fh        <= FRAME_HEIGHT_RST;
            r_col       <= '0;
            r_row       <= '0;
            r_emitted   <= '0;
            r_win       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_FRAME_WIDTH || i_cfg_index == CFG_FRAME_HEIGHT) begin
                    r_col     <= '0;
                    r_row     <= '0;
                    r_emitted <= '0;
                    r_win     <= '0;
                end
                if (i_cfg_index == CFG_FRAME_WIDTH) begin
                    r_fw <= FW_BITS'(i_cfg_data);
                end
                if (i_cfg_index == CFG_FRAME_HEIGHT) begin
                    r_fh <= i_cfg_data;
                end
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid && (draining || i_in_data.operation == OP_PIXEL)) begin
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_COL;
                end
                S_COL: begin
                    if (emit && last_out) begin
                        r_col     <= '0;
                        r_row     <= '0;
                        r_emitted <= '0;
                        r_win     <= '0;
                    end else begin
                        r_win[0] <= r_win[1];
                        r_win[1] <= r_win[2];
                        r_win[2] <= col;
                        if (c_inc >= w_eff) begin
                            r_col <= '0;
                            r_row <= r_row + ROW_W'(1);
                        end else begin
                            r_col <= CW'(c_inc);
                        end
                        if (emit) begin
                            r_emitted <= r_emitted + EW'(1);
                        end
                    end
                    r_state <= emit ? S_LANE : S_IDLE;
                end
                S_LANE: begin
                    if (lane_done[0]) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_total <= EW'(w_eff) * EW'(h_eff);
        if (r_state == S_IDLE) begin
            r_drain <= draining;
            r_pix   <= draining ? '0 : {i_in_data.in_red, i_in_data.in_green, i_in_data.in_blue};
        end
        if (r_state == S_COL) begin
            r_last <= last_out;
        end
        if (out_load) begin
            r_out.out_blue   <= lane_mag[0];
            r_out.out_green  <= lane_mag[1];
            r_out.out_red    <= lane_mag[2];
            r_out.frame_last <= r_last;
        end
    end

    assign r_win_valid_unused = '0;
    assign o_in_ready  = (r_state == S_IDLE) && (r_win_valid_unused == '0);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = (r_state == S_IDLE);

    a_lanes_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        lane_done[0] |-> (lane_done[1] && lane_done[2]))
        else $error("Channel lanes finished out of step.");

    a_done_only_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        lane_done[0] |-> (r_state == S_LANE))
        else $error("Lane finished outside the lane wait state.");

    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COL && emit && last_out && !i_cfg_valid)
        |=> (r_emitted == '0 && r_row == '0 && r_col == '0))
        else $error("Frame counters not cleared after the last output.");

    a_load_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && r_out_valid) |-> i_out_ready)
        else $error("Output stage overwritten before its transfer.");

endmodule
